// File: hw/rtl/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg: shared types and constants of the trajectory RMSE block
// Field widths, word layouts, result status codes and the operation codes
// of the shared divide / square root unit.
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int POS_W     = 20;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQ_W      = 2 * POS_W;
    localparam int DSQ_W     = SQ_W + 1;
    localparam int SUM_W     = 59;
    localparam int CNT_W     = 17;
    localparam int OUT_W     = 21;
    localparam int MAX_PAIRS = 65536;

    // Shared divide / square root datapath.
    localparam int DS_W      = 33;
    localparam int RAD_W     = SUM_W + 1;
    localparam int ITER_W    = 6;
    localparam int DIV_ITERS = SUM_W;
    localparam int SQRT_ITERS = RAD_W / 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DATA   = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_ds_ctrl;

    typedef struct packed {
        logic signed [POS_W-1:0] est_x;
        logic signed [POS_W-1:0] est_y;
        logic signed [POS_W-1:0] ref_x;
        logic signed [POS_W-1:0] ref_y;
        logic                    est_present;
        logic                    ref_present;
        logic                    last_item;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] rmse;
        logic [OUT_W-1:0] end_dist;
        logic [CNT_W-1:0] pair_count;
        t_status          status;
    } t_out_word;

endpackage

// File: hw/rtl/tre_ifs.sv
// ----------------------------------------------------------------------------
// tre_ifs: valid / ready channels of the trajectory RMSE block
// One channel carries input words, the other carries result words.
// ----------------------------------------------------------------------------
interface tre_in_if;
    import tre_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tre_out_if;
    import tre_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tre_sqr.sv
// ----------------------------------------------------------------------------
// tre_sqr: registered squarer
// Squares one signed coordinate difference per cycle; the product is
// registered and available in the cycle after the operand.
// ----------------------------------------------------------------------------
module tre_sqr (
    input  logic                               i_clk,
    input  logic signed [tre_pkg::DIFF_W-1:0]  i_val,
    output logic        [tre_pkg::SQ_W-1:0]    o_sq
);
    import tre_pkg::*;

    logic signed [2*DIFF_W-1:0] w_prod;
    logic        [SQ_W-1:0]     r_sq;

    assign w_prod = i_val * i_val;

    // The magnitude of a difference stays below 2^POS_W, so the square fits.
    always_ff @(posedge i_clk) begin
        r_sq <= w_prod[SQ_W-1:0];
    end

    assign o_sq = r_sq;

endmodule

// File: hw/rtl/tre_divsqrt.sv
// ----------------------------------------------------------------------------
// tre_divsqrt: iterative divide and integer square root
// One shared subtract-and-compare stage produces one quotient bit or one
// root bit per cycle. Division takes one radicand bit per step, the square
// root two.
// ----------------------------------------------------------------------------
module tre_divsqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tre_pkg::t_ds_ctrl           i_ctrl,
    input  logic [tre_pkg::SUM_W-1:0]   i_arg,
    input  logic [tre_pkg::CNT_W-1:0]   i_div,
    output logic                        o_done,
    output logic [tre_pkg::SUM_W-1:0]   o_res
);
    import tre_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_op               r_op;
    logic [ITER_W-1:0] r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [DS_W-1:0]   r_rem;
    logic [SUM_W-1:0]  r_res;
    logic [CNT_W-1:0]  r_div;

    logic [DS_W-1:0]   w_cand;
    logic [DS_W-1:0]   w_sub;
    logic [DS_W:0]     w_diff;
    logic              w_fits;
    logic [DS_W-1:0]   n_rem;

    always_comb begin
        if (r_op == OP_DIV) begin
            w_cand = {r_rem[DS_W-2:0], r_rad[RAD_W-1]};
            w_sub  = {{(DS_W-CNT_W){1'b0}}, r_div};
        end else begin
            w_cand = {r_rem[DS_W-3:0], r_rad[RAD_W-1 -: 2]};
            // Trial value for the root is the partial root followed by 01.
            w_sub  = {1'b0, r_res[DS_W-4:0], 2'b01};
        end
        w_diff = {1'b0, w_cand} - {1'b0, w_sub};
        w_fits = !w_diff[DS_W];
        n_rem  = w_fits ? w_diff[DS_W-1:0] : w_cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_op  <= i_ctrl.op;
            r_rem <= '0;
            r_res <= '0;
            r_div <= i_div;
            if (i_ctrl.op == OP_DIV) begin
                r_cnt <= ITER_W'(DIV_ITERS - 1);
                r_rad <= {i_arg, 1'b0};
            end else begin
                r_cnt <= ITER_W'(SQRT_ITERS - 1);
                r_rad <= {1'b0, i_arg};
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_res <= {r_res[SUM_W-2:0], w_fits};
            r_cnt <= r_cnt - 1'b1;
            if (r_op == OP_DIV) begin
                r_rad <= {r_rad[RAD_W-2:0], 1'b0};
            end else begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: hw/rtl/trajectory_rmse_final_error_top.sv
// ----------------------------------------------------------------------------
// trajectory_rmse_final_error_top: RMSE and final error of a 2D trajectory
// Accumulates squared estimate-to-reference distances, then on the last
// word of a run reports root mean square error and final point distance.
// ----------------------------------------------------------------------------
// A word without a pair passes S_IDLE and S_ACC; with both points it also passes
// S_SQ_X, S_SQ_Y and S_ADD, as the single squarer takes x, then y. A last word
// with both sides seen adds the final distance square, then on the shared subtractor
// a 30-step square root and, if pairs were seen, a 59-step divide and a second
// 30-step root. The result sits in an output register, so the next run can
// start while it waits. Synchronous active-low reset clears run state, output valid.
module trajectory_rmse_final_error_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tre_in_if.sink     i_item,
    tre_out_if.source  o_result
);
    import tre_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_ADD,
        S_ACC,
        S_FIN_SQRT,
        S_FIN_WAIT,
        S_DIV,
        S_DIV_WAIT,
        S_RMS_SQRT,
        S_RMS_WAIT,
        S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_pair, n_pair;
    logic                      r_last, n_last;
    logic                      r_final, n_final;
    logic signed [DIFF_W-1:0]  r_dx, n_dx;
    logic signed [DIFF_W-1:0]  r_dy, n_dy;
    logic [DSQ_W-1:0]          r_dsq, n_dsq;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [CNT_W-1:0]          r_pairs, n_pairs;
    logic signed [POS_W-1:0]   r_ex, n_ex, r_ey, n_ey;
    logic signed [POS_W-1:0]   r_rx, n_rx, r_ry, n_ry;
    logic                      r_est_seen, n_est_seen;
    logic                      r_ref_seen, n_ref_seen;
    logic                      r_sat, n_sat;
    logic [OUT_W-1:0]          r_fin, n_fin;
    logic [OUT_W-1:0]          r_rmse, n_rmse;
    t_status                   r_status, n_status;
    logic                      r_out_valid, n_out_valid;
    t_out_word                 r_out, n_out;

    logic signed [DIFF_W-1:0]  w_sqr_in;
    logic [SQ_W-1:0]           w_sq;
    t_ds_ctrl                  w_ds_ctrl;
    logic [SUM_W-1:0]          w_ds_arg;
    logic                      w_ds_done;
    logic [SUM_W-1:0]          w_ds_res;
    logic [SUM_W:0]            w_sum_ext;
    logic                      w_accept;

    assign w_accept     = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_sqr_in     = (r_state == S_SQ_X) ? r_dx : r_dy;
    assign w_sum_ext    = {1'b0, r_sum} + {{(SUM_W+1-DSQ_W){1'b0}}, r_dsq};

    tre_sqr u_sqr (
        .i_clk (i_clk),
        .i_val (w_sqr_in),
        .o_sq  (w_sq)
    );

    always_comb begin
        w_ds_ctrl.start = 1'b0;
        w_ds_ctrl.op    = OP_SQRT;
        w_ds_arg        = w_ds_res;
        unique case (r_state)
            S_FIN_SQRT: begin
                w_ds_ctrl.start = 1'b1;
                w_ds_arg        = {{(SUM_W-DSQ_W){1'b0}}, r_dsq};
            end
            S_DIV: begin
                w_ds_ctrl.start = 1'b1;
                w_ds_ctrl.op    = OP_DIV;
                w_ds_arg        = r_sum;
            end
            S_RMS_SQRT: begin
                w_ds_ctrl.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tre_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ds_ctrl),
        .i_arg   (w_ds_arg),
        .i_div   (r_pairs),
        .o_done  (w_ds_done),
        .o_res   (w_ds_res)
    );

    always_comb begin
        n_state     = r_state;
        n_pair      = r_pair;
        n_last      = r_last;
        n_final     = r_final;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dsq       = r_dsq;
        n_sum       = r_sum;
        n_pairs     = r_pairs;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_est_seen  = r_est_seen;
        n_ref_seen  = r_ref_seen;
        n_sat       = r_sat;
        n_fin       = r_fin;
        n_rmse      = r_rmse;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pair  = i_item.data.est_present && i_item.data.ref_present;
                    n_last  = i_item.data.last_item;
                    n_final = 1'b0;
                    n_dx    = {i_item.data.est_x[POS_W-1], i_item.data.est_x}
                            - {i_item.data.ref_x[POS_W-1], i_item.data.ref_x};
                    n_dy    = {i_item.data.est_y[POS_W-1], i_item.data.est_y}
                            - {i_item.data.ref_y[POS_W-1], i_item.data.ref_y};
                    if (i_item.data.est_present) begin
                        n_ex       = i_item.data.est_x;
                        n_ey       = i_item.data.est_y;
                        n_est_seen = 1'b1;
                    end
                    if (i_item.data.ref_present) begin
                        n_rx       = i_item.data.ref_x;
                        n_ry       = i_item.data.ref_y;
                        n_ref_seen = 1'b1;
                    end
                    n_state = n_pair ? S_SQ_X : S_ACC;
                end
            end
            S_SQ_X: begin
                n_state = S_SQ_Y;
            end
            S_SQ_Y: begin
                n_dsq   = {1'b0, w_sq};
                n_state = S_ADD;
            end
            S_ADD: begin
                n_dsq   = r_dsq + {1'b0, w_sq};
                n_state = r_final ? S_FIN_SQRT : S_ACC;
            end
            S_ACC: begin
                if (r_pair) begin
                    if (r_pairs == CNT_W'(MAX_PAIRS)) begin
                        n_sat = 1'b1;
                    end else begin
                        // A carry into the top bit means the sum passed its ceiling.
                        if (w_sum_ext[SUM_W]) begin
                            n_sum = '1;
                            n_sat = 1'b1;
                        end else begin
                            n_sum = w_sum_ext[SUM_W-1:0];
                        end
                        n_pairs = r_pairs + 1'b1;
                    end
                end
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!(r_est_seen && r_ref_seen)) begin
                    n_rmse   = '0;
                    n_fin    = '0;
                    n_status = ST_NO_DATA;
                    n_state  = S_OUT;
                end else begin
                    n_dx    = {r_ex[POS_W-1], r_ex} - {r_rx[POS_W-1], r_rx};
                    n_dy    = {r_ey[POS_W-1], r_ey} - {r_ry[POS_W-1], r_ry};
                    n_final = 1'b1;
                    n_state = S_SQ_X;
                end
            end
            S_FIN_SQRT: begin
                n_state = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                if (w_ds_done) begin
                    n_fin = w_ds_res[OUT_W-1:0];
                    if (r_pairs == '0) begin
                        n_rmse   = '0;
                        n_status = ST_NO_DATA;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_ds_done) begin
                    n_state = S_RMS_SQRT;
                end
            end
            S_RMS_SQRT: begin
                n_state = S_RMS_WAIT;
            end
            S_RMS_WAIT: begin
                if (w_ds_done) begin
                    n_rmse   = w_ds_res[OUT_W-1:0];
                    n_status = r_sat ? ST_SATURATED : ST_OK;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid      = 1'b1;
                    n_out.rmse       = r_rmse;
                    n_out.end_dist   = r_fin;
                    n_out.pair_count = r_pairs;
                    n_out.status     = r_status;
                    // The run is over: start the next one from a clean slate.
                    n_sum      = '0;
                    n_pairs    = '0;
                    n_ex       = '0;
                    n_ey       = '0;
                    n_rx       = '0;
                    n_ry       = '0;
                    n_est_seen = 1'b0;
                    n_ref_seen = 1'b0;
                    n_sat      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_pairs     <= '0;
            r_ex        <= '0;
            r_ey        <= '0;
            r_rx        <= '0;
            r_ry        <= '0;
            r_est_seen  <= 1'b0;
            r_ref_seen  <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_pairs     <= n_pairs;
            r_ex        <= n_ex;
            r_ey        <= n_ey;
            r_rx        <= n_rx;
            r_ry        <= n_ry;
            r_est_seen  <= n_est_seen;
            r_ref_seen  <= n_ref_seen;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair   <= n_pair;
        r_last   <= n_last;
        r_final  <= n_final;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_dsq    <= n_dsq;
        r_fin    <= n_fin;
        r_rmse   <= n_rmse;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    a_pairs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= CNT_W'(MAX_PAIRS))
        else $error("pair count exceeds its limit");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_done |-> (r_state == S_FIN_WAIT || r_state == S_DIV_WAIT ||
                       r_state == S_RMS_WAIT))
        else $error("divide/sqrt unit finished outside a wait state");

    a_zero_pairs_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pair_count == '0) |-> r_out.status == ST_NO_DATA)
        else $error("result without pairs not flagged as no data");

    a_no_data_zero_rmse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_NO_DATA) |-> r_out.rmse == '0)
        else $error("no-data result carries a nonzero rmse");

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_IDLE) |=>
            (r_pairs == '0 && !r_est_seen && !r_ref_seen && !r_sat))
        else $error("run state not cleared after a result");

endmodule

// File: verif/tb_trajectory_rmse_final_error_top.sv
// ----------------------------------------------------------------------------
// tb_trajectory_rmse_final_error_top: self-checking bench for trajectory RMSE
// Feeds runs of estimate / reference points into the block, keeps its own
// running sum, pair count and last points, and compares every result word
// with the predicted RMSE, final distance, pair count and status. Directed
// runs cover one-sided and empty runs and extreme points.
// Long random runs follow, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_trajectory_rmse_final_error_top;
    import tre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SUM_LIMIT    = 64'h07FF_FFFF_FFFF_FFFF;
    localparam int          RANDOM_WORDS = 1600;
    localparam int          LONG_HOLD_AT = 12;
    localparam int          LONG_HOLD    = 400;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          MAX_REPORTS  = 100;

    typedef struct {
        t_in_word word;
        int       gap;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    tre_in_if  item_ch ();
    tre_out_if result_ch ();

    trajectory_rmse_final_error_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Words waiting to be sent and result words still to come.
    t_pending  pending_words[$];
    t_out_word expected_results[$];

    // Running state of the trajectory comparison.
    logic [63:0]             sum_acc;
    logic [CNT_W-1:0]        pair_total;
    logic signed [POS_W-1:0] est_px, est_py, ref_px, ref_py;
    logic                    est_valid_seen, ref_valid_seen, overflowed;

    int error_count = 0;
    int results_seen = 0;
    int hold_cnt;
    int stall_left;
    int next_stall;
    int random_words;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] span_sq(input logic signed [POS_W-1:0] ax, ay, bx, by);
        longint dx, dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return 64'(dx * dx) + 64'(dy * dy);
    endfunction

    // Truncated square root, one result bit per step from the top down.
    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = {32'b0, root | (32'b1 << b)};
            if (trial * trial <= v) begin
                root = root | (32'b1 << b);
            end
        end
        return root;
    endfunction

    task automatic clear_run();
        sum_acc        = '0;
        pair_total     = '0;
        est_px         = '0;
        est_py         = '0;
        ref_px         = '0;
        ref_py         = '0;
        est_valid_seen = 1'b0;
        ref_valid_seen = 1'b0;
        overflowed     = 1'b0;
    endtask

    task automatic track_word(input t_in_word w);
        logic [63:0] sq;
        logic [31:0] root;
        t_out_word   res;
        if (w.est_present && w.ref_present) begin
            if (pair_total >= MAX_PAIRS) begin
                overflowed = 1'b1;
            end else begin
                sq = span_sq(w.est_x, w.est_y, w.ref_x, w.ref_y);
                if (sq > SUM_LIMIT - sum_acc) begin
                    sum_acc    = SUM_LIMIT;
                    overflowed = 1'b1;
                end else begin
                    sum_acc = sum_acc + sq;
                end
                pair_total = pair_total + 1'b1;
            end
        end
        if (w.est_present) begin
            est_px         = w.est_x;
            est_py         = w.est_y;
            est_valid_seen = 1'b1;
        end
        if (w.ref_present) begin
            ref_px         = w.ref_x;
            ref_py         = w.ref_y;
            ref_valid_seen = 1'b1;
        end
        if (w.last_item) begin
            res.rmse       = '0;
            res.end_dist   = '0;
            res.pair_count = pair_total;
            if (!est_valid_seen || !ref_valid_seen) begin
                res.status = ST_NO_DATA;
            end else begin
                root         = floor_sqrt(span_sq(est_px, est_py, ref_px, ref_py));
                res.end_dist = root[OUT_W-1:0];
                if (pair_total == 0) begin
                    res.status = ST_NO_DATA;
                end else begin
                    root       = floor_sqrt(sum_acc / pair_total);
                    res.rmse   = root[OUT_W-1:0];
                    res.status = overflowed ? ST_SATURATED : ST_OK;
                end
            end
            expected_results = {expected_results, res};
            clear_run();
        end
    endtask

    function automatic logic signed [POS_W-1:0] any_coord();
        logic [31:0] v;
        v = $urandom;
        return v[POS_W-1:0];
    endfunction

    // A point near the given one, so that small distances are exercised too.
    function automatic logic signed [POS_W-1:0] near_coord(input logic signed [POS_W-1:0] c);
        logic [POS_W-1:0] d;
        d = POS_W'($urandom_range(0, 2047)) - POS_W'(1024);
        return c + d;
    endfunction

    function automatic int pick_gap(input bit calm);
        if (calm || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic queue_word(input logic signed [POS_W-1:0] ex, ey, rx, ry,
                              input bit has_est, has_ref, last, input int gap);
        t_pending p;
        p.word.est_x       = ex;
        p.word.est_y       = ey;
        p.word.ref_x       = rx;
        p.word.ref_y       = ry;
        p.word.est_present = has_est;
        p.word.ref_present = has_ref;
        p.word.last_item   = last;
        p.gap              = gap;
        pending_words = {pending_words, p};
    endtask

    task automatic queue_pair(input logic signed [POS_W-1:0] ex, ey, rx, ry, input bit last);
        queue_word(ex, ey, rx, ry, 1'b1, 1'b1, last, $urandom_range(0, 7));
    endtask

    // A word whose point fields carry noise that the block must ignore.
    task automatic queue_side(input bit has_est, has_ref, last,
                              input logic signed [POS_W-1:0] px, py);
        queue_word(has_est ? px : any_coord(), has_est ? py : any_coord(),
                   has_ref ? px : any_coord(), has_ref ? py : any_coord(),
                   has_est, has_ref, last, $urandom_range(0, 7));
    endtask

    task automatic queue_random_run();
        int                      len;
        int                      kind;
        bit                      calm;
        bit                      one_sided;
        bit                      has_est, has_ref;
        logic signed [POS_W-1:0] ex, ey, rx, ry;
        len       = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        calm      = ($urandom_range(0, 3) == 0);
        one_sided = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            kind    = $urandom_range(0, 9);
            has_est = (kind <= 7) && !(one_sided && kind >= 4);
            has_ref = (kind <= 6 && !one_sided) || kind == 8
                    || (one_sided && kind >= 4 && kind <= 7);
            case ($urandom_range(0, 5))
                0: begin
                    ex = any_coord();
                    ey = any_coord();
                    rx = any_coord();
                    ry = any_coord();
                end
                1: begin
                    ex = $urandom_range(0, 1) ? '1 << (POS_W - 1) : ~('1 << (POS_W - 1));
                    ey = $urandom_range(0, 1) ? '1 << (POS_W - 1) : ~('1 << (POS_W - 1));
                    rx = $urandom_range(0, 1) ? '1 << (POS_W - 1) : ~('1 << (POS_W - 1));
                    ry = $urandom_range(0, 1) ? '1 << (POS_W - 1) : ~('1 << (POS_W - 1));
                end
                default: begin
                    ex = any_coord();
                    ey = any_coord();
                    rx = near_coord(ex);
                    ry = near_coord(ey);
                end
            endcase
            if (!has_est) begin
                ex = any_coord();
                ey = any_coord();
            end
            if (!has_ref) begin
                rx = any_coord();
                ry = any_coord();
            end
            queue_word(ex, ey, rx, ry, has_est, has_ref, i == len - 1, pick_gap(calm));
            if (has_est || has_ref || i == len - 1) begin
                random_words++;
            end
        end
    endtask

    // Sender: a word leaves the queue once the previous one was taken and
    // its gap has run out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            hold_cnt      <= 0;
            clear_run();
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                track_word(item_ch.data);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (hold_cnt != 0) begin
                    item_ch.valid <= 1'b0;
                    hold_cnt      <= hold_cnt - 1;
                end else if (pending_words.size() != 0) begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= pending_words[0].word;
                    hold_cnt      <= pending_words[0].gap;
                    void'(pending_words.pop_front());
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint exp_v, act_v);
        if (exp_v != act_v) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
                         $time, results_seen, name, exp_v, act_v);
            end
        end
    endtask

    // Receiver: checks each result word, then stalls for a drawn number of
    // cycles; once it holds off long enough for the block to back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else if (result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word, expected none, actual %p",
                         $time, result_ch.data);
            end else begin
                check_field("rmse", expected_results[0].rmse, result_ch.data.rmse);
                check_field("end_dist", expected_results[0].end_dist,
                            result_ch.data.end_dist);
                check_field("pair_count", expected_results[0].pair_count,
                            result_ch.data.pair_count);
                check_field("status", expected_results[0].status, result_ch.data.status);
                void'(expected_results.pop_front());
            end
            results_seen++;
            next_stall = (results_seen == LONG_HOLD_AT) ? LONG_HOLD : pick_gap(1'b0);
            stall_left      <= next_stall;
            result_ch.ready <= (next_stall == 0);
        end else if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= (stall_left == 1);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        random_words = 0;

        // Empty run, then runs with only one side present.
        queue_side(1'b0, 1'b0, 1'b1, any_coord(), any_coord());
        queue_side(1'b1, 1'b0, 1'b0, 20'sh7FFFF, 20'sh7FFFF);
        queue_side(1'b0, 1'b0, 1'b1, any_coord(), any_coord());
        queue_side(1'b0, 1'b1, 1'b0, 20'sh80000, 20'sh80000);
        queue_side(1'b0, 1'b0, 1'b1, any_coord(), any_coord());
        // Both sides seen but never in the same word.
        queue_side(1'b1, 1'b0, 1'b0, 20'sh80000, 20'sh80000);
        queue_side(1'b0, 1'b1, 1'b0, 20'sh7FFFF, 20'sh7FFFF);
        queue_side(1'b0, 1'b0, 1'b1, any_coord(), any_coord());
        // Largest possible distance on a single pair marked last.
        queue_pair(20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 1'b1);
        // Identical points give zero distance.
        queue_pair(20'sh00000, 20'sh00000, 20'sh00000, 20'sh00000, 1'b1);
        // Last word moves only the estimate point.
        queue_pair(20'sh00000, 20'sh7FFFF, 20'sh00000, 20'sh7FFFF, 1'b0);
        queue_pair(20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh7FFFF, 1'b0);
        queue_side(1'b1, 1'b0, 1'b1, 20'sh00001, 20'shFFFFF);
        // Last word moves only the reference point.
        queue_pair(20'sh12345, 20'shABCDE, 20'sh12300, 20'shABC00, 1'b0);
        queue_pair(20'sh00FFF, 20'shFF000, 20'sh01000, 20'shFEFFF, 1'b0);
        queue_side(1'b0, 1'b1, 1'b1, 20'sh55555, 20'shAAAAA);
        // Last word carries no point at all.
        queue_pair(20'sh00001, 20'sh00001, 20'shFFFFF, 20'shFFFFF, 1'b0);
        queue_side(1'b0, 1'b0, 1'b1, any_coord(), any_coord());

        while (random_words < RANDOM_WORDS) begin
            queue_random_run();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || item_ch.valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("%0t: timeout, %0d result words still outstanding",
                 $time, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
